@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared constants, field types and the structs passed between the sequencer,
// the slot memory and the scan/compare unit.
// ----------------------------------------------------------------------------
package pps_pkg;

   // Task table depth
   localparam int SLOTS      = 16;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Field widths
   localparam int ID_W    = 8;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int ORDER_W = 16;

   // Request op codes
   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;
   typedef logic [ID_W-1:0]       id_type;
   typedef logic [BURST_W-1:0]    burst_type;
   typedef logic [PRIO_W-1:0]     prio_type;
   typedef logic [ORDER_W-1:0]    order_type;

   // One task table entry
   typedef struct packed {
      id_type    task_id;
      burst_type remaining;
      prio_type  prio;
      order_type order;
   } slot_entry_type;

   // Scan control from the sequencer to the compare unit
   typedef struct packed {
      logic         start;
      logic         eval_en;
      logic         eval_valid;
      slot_idx_type eval_idx;
      logic         have_cur;
      slot_idx_type cur_idx;
   } scan_ctl_type;

   // Selected task after a scan
   typedef struct packed {
      logic           found;
      slot_idx_type   idx;
      slot_entry_type entry;
   } pick_type;

endpackage

@@ rtl/pps_slot_mem.sv @@
// ----------------------------------------------------------------------------
// Task slot memory
// Table of task entries with separate write and read ports, one write and one read per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module pps_slot_mem (
   input  logic                    clock,
   input  logic                    wr_en,
   input  pps_pkg::slot_idx_type   wr_addr,
   input  pps_pkg::slot_entry_type wr_data,
   input  logic                    rd_en,
   input  pps_pkg::slot_idx_type   rd_addr,
   output pps_pkg::slot_entry_type rd_data
);

   pps_pkg::slot_entry_type slot_mem_ff [pps_pkg::SLOTS];
   pps_pkg::slot_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pps_picker.sv @@
// ----------------------------------------------------------------------------
// Scan compare unit
// One priority/order comparator applied to one table entry per cycle.
// Tracks the best waiting entry and the running entry, then resolves
// preemption.
// ----------------------------------------------------------------------------
module pps_picker (
   input  logic                    clock,
   input  logic                    reset,
   input  pps_pkg::scan_ctl_type   ctl,
   input  pps_pkg::slot_entry_type rd_data,
   output pps_pkg::pick_type       pick
);

   logic                    best_found_ff, best_found_in;
   pps_pkg::slot_idx_type   best_idx_ff, best_idx_in;
   pps_pkg::slot_entry_type best_entry_ff, best_entry_in;
   pps_pkg::slot_entry_type cur_entry_ff, cur_entry_in;
   logic                    is_before;
   logic                    preempt;

   // a goes ahead of b: more urgent, or same priority and earlier arrival
   function automatic logic sched_before(input pps_pkg::slot_entry_type a,
                                         input pps_pkg::slot_entry_type b);
      logic res;
      res = (a.prio < b.prio) || ((a.prio == b.prio) && (a.order < b.order));
      return res;
   endfunction

   assign is_before = sched_before(rd_data, best_entry_ff);

   // Compare step: strict compare keeps the lower index on a full tie
   always_comb begin
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_entry_in = best_entry_ff;
      cur_entry_in  = cur_entry_ff;
      if (ctl.start) begin
         best_found_in = 1'b0;
      end else if (ctl.eval_en) begin
         if (ctl.have_cur && (ctl.eval_idx == ctl.cur_idx)) begin
            cur_entry_in = rd_data;
         end else if (ctl.eval_valid && (!best_found_ff || is_before)) begin
            best_found_in = 1'b1;
            best_idx_in   = ctl.eval_idx;
            best_entry_in = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else begin
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_entry_ff <= best_entry_in;
      cur_entry_ff  <= cur_entry_in;
   end

   // Preemption: only a strictly more urgent waiting task takes over
   assign preempt = best_found_ff && (best_entry_ff.prio < cur_entry_ff.prio);

   always_comb begin
      if (ctl.have_cur && !preempt) begin
         pick.found = 1'b1;
         pick.idx   = ctl.cur_idx;
         pick.entry = cur_entry_ff;
      end else begin
         pick.found = best_found_ff;
         pick.idx   = best_idx_ff;
         pick.entry = best_entry_ff;
      end
   end

endmodule

@@ rtl/preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Task table with arrive and tick operations; one comparator scans the table.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel (valid/ready) carries one operation. req_op selects an
//   arrival (task id, burst, priority) or a tick of one time unit.
//   rsp_* channel (valid/ready) returns one result per request: the id run
//   on a tick, idle when nothing could run, finished when the task used up
//   its burst, rejected when an arrival found the table full.
//   An arrival goes from transfer through the arrive step to its result; a
//   tick scans all SLOTS entries, as the comparator reads the slot memory
//   one entry per cycle, then passes the drain and commit steps.
//   One request is in work at a time; req_ready is high only while idle.
//   The result register holds a finished result while the next request is
//   taken in; if the receiver stalls, the block waits at its arrive or commit
//   step until the result register frees up.
//   Reset empties the table, clears the arrival counter and the running
//   task; no clearing pass is needed.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [7:0]             req_task_id,
   input  logic [15:0]            req_burst,
   input  logic [7:0]             req_prio,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_running_id,
   output logic                   rsp_idle,
   output logic                   rsp_finished,
   output logic                   rsp_rejected
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ARRIVE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Latched request
   pps_pkg::id_type    req_task_id_ff;
   pps_pkg::burst_type req_burst_ff;
   pps_pkg::prio_type  req_prio_ff;

   // Scheduler state
   logic [pps_pkg::SLOTS-1:0] slot_valid_ff, slot_valid_in;
   pps_pkg::order_type        arrival_ctr_ff, arrival_ctr_in;
   logic                      running_valid_ff, running_valid_in;
   pps_pkg::slot_idx_type     running_idx_ff, running_idx_in;

   // Scan sequencing
   pps_pkg::slot_idx_type scan_cnt_ff, scan_cnt_in;
   logic                  eval_en_ff, eval_en_in;
   pps_pkg::slot_idx_type eval_idx_ff, eval_idx_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   pps_pkg::id_type rsp_id_ff, rsp_id_in;
   logic            rsp_idle_ff, rsp_idle_in;
   logic            rsp_fin_ff, rsp_fin_in;
   logic            rsp_rej_ff, rsp_rej_in;

   // Memory and compare unit hookup
   logic                    mem_wr_en;
   pps_pkg::slot_idx_type   mem_wr_addr;
   pps_pkg::slot_entry_type mem_wr_data;
   logic                    mem_rd_en;
   pps_pkg::slot_entry_type mem_rd_data;
   pps_pkg::scan_ctl_type   scan_ctl;
   pps_pkg::pick_type       pick;

   logic                  req_xfer;
   logic                  out_free;
   logic                  free_found;
   pps_pkg::slot_idx_type free_idx;
   logic                  pick_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pick_last = (pick.entry.remaining[pps_pkg::BURST_W-1:1] == '0);

   // Lowest free entry
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = pps_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = pps_pkg::slot_idx_type'(i);
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      slot_valid_in    = slot_valid_ff;
      arrival_ctr_in   = arrival_ctr_ff;
      running_valid_in = running_valid_ff;
      running_idx_in   = running_idx_ff;
      scan_cnt_in      = scan_cnt_ff;
      eval_en_in       = 1'b0;
      eval_idx_in      = scan_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_id_in        = rsp_id_ff;
      rsp_idle_in      = rsp_idle_ff;
      rsp_fin_in       = rsp_fin_ff;
      rsp_rej_in       = rsp_rej_ff;
      mem_wr_en        = 1'b0;
      mem_wr_addr      = free_idx;
      mem_wr_data      = '0;
      mem_rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               scan_cnt_in = '0;
               if (req_op == pps_pkg::OP_ARRIVE) begin
                  state_in = ST_ARRIVE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_ARRIVE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_idle_in  = 1'b0;
               rsp_fin_in   = 1'b0;
               rsp_rej_in   = !free_found;
               if (free_found) begin
                  mem_wr_en                 = 1'b1;
                  mem_wr_addr               = free_idx;
                  mem_wr_data.task_id       = req_task_id_ff;
                  mem_wr_data.remaining     = (req_burst_ff == '0) ?
                                              pps_pkg::burst_type'(1) : req_burst_ff;
                  mem_wr_data.prio          = req_prio_ff;
                  mem_wr_data.order         = arrival_ctr_ff;
                  slot_valid_in[free_idx]   = 1'b1;
                  arrival_ctr_in            = arrival_ctr_ff + pps_pkg::order_type'(1);
               end
            end
         end

         // One entry read per cycle; the compare acts on the registered read data
         ST_SCAN: begin
            mem_rd_en   = 1'b1;
            eval_en_in  = 1'b1;
            eval_idx_in = scan_cnt_ff;
            if (scan_cnt_ff == pps_pkg::slot_idx_type'(pps_pkg::SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_cnt_in = scan_cnt_ff + pps_pkg::slot_idx_type'(1);
            end
         end

         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end

         // Run the picked task for one unit, or report idle when none is found
         ST_COMMIT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_rej_in   = 1'b0;
               if (!pick.found) begin
                  running_valid_in = 1'b0;
                  rsp_id_in        = '0;
                  rsp_idle_in      = 1'b1;
                  rsp_fin_in       = 1'b0;
               end else begin
                  rsp_id_in   = pick.entry.task_id;
                  rsp_idle_in = 1'b0;
                  if (pick_last) begin
                     slot_valid_in[pick.idx] = 1'b0;
                     running_valid_in        = 1'b0;
                     rsp_fin_in              = 1'b1;
                  end else begin
                     mem_wr_en             = 1'b1;
                     mem_wr_addr           = pick.idx;
                     mem_wr_data           = pick.entry;
                     mem_wr_data.remaining = pick.entry.remaining -
                                             pps_pkg::burst_type'(1);
                     running_valid_in      = 1'b1;
                     running_idx_in        = pick.idx;
                     rsp_fin_in            = 1'b0;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         slot_valid_ff    <= '0;
         arrival_ctr_ff   <= '0;
         running_valid_ff <= 1'b0;
         eval_en_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         slot_valid_ff    <= slot_valid_in;
         arrival_ctr_ff   <= arrival_ctr_in;
         running_valid_ff <= running_valid_in;
         eval_en_ff       <= eval_en_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      running_idx_ff <= running_idx_in;
      scan_cnt_ff    <= scan_cnt_in;
      eval_idx_ff    <= eval_idx_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_idle_ff    <= rsp_idle_in;
      rsp_fin_ff     <= rsp_fin_in;
      rsp_rej_ff     <= rsp_rej_in;
      if (req_xfer) begin
         req_task_id_ff <= req_task_id;
         req_burst_ff   <= req_burst;
         req_prio_ff    <= req_prio;
      end
   end

   // Compare unit control
   always_comb begin
      scan_ctl.start      = req_xfer && (req_op == pps_pkg::OP_TICK);
      scan_ctl.eval_en    = eval_en_ff;
      scan_ctl.eval_valid = slot_valid_ff[eval_idx_ff];
      scan_ctl.eval_idx   = eval_idx_ff;
      scan_ctl.have_cur   = running_valid_ff && slot_valid_ff[running_idx_ff];
      scan_ctl.cur_idx    = running_idx_ff;
   end

   pps_slot_mem u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (scan_cnt_ff),
      .rd_data (mem_rd_data)
   );

   pps_picker u_picker (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_data (mem_rd_data),
      .pick    (pick)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_running_id = rsp_id_ff;
   assign rsp_idle       = rsp_idle_ff;
   assign rsp_finished   = rsp_fin_ff;
   assign rsp_rejected   = rsp_rej_ff;

endmodule

@@ rtl/pps_checker.sv @@
// ----------------------------------------------------------------------------
// Preemptive priority scheduler port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
module pps_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_running_id,
   input  logic       rsp_idle,
   input  logic       rsp_finished,
   input  logic       rsp_rejected
);

   // Held result keeps its id and finished flag while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_id)
                                 && $stable(rsp_finished))
      else $error("result changed while stalled");

   // An idle tick reports no task, nothing finished and no rejection
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_idle |-> (rsp_running_id == 8'd0) && !rsp_finished
                                && !rsp_rejected)
      else $error("idle result carries a task");

   // A rejected arrival reports nothing run
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> (rsp_running_id == 8'd0) && !rsp_idle)
      else $error("rejected result carries tick flags");

   // One request in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_running_id (rsp_running_id),
   .rsp_idle       (rsp_idle),
   .rsp_finished   (rsp_finished),
   .rsp_rejected   (rsp_rejected)
);
